### rtl/syr_pkg.sv
// Shared types, codes and helpers for the shunting-yard infix-to-postfix converter.
// Used by syr_front, syr_back and the top level; depends on nothing.
package syr_pkg;

    // Sizes.
    localparam int STACK_DEPTH  = 32;
    localparam int PAYLOAD_BITS = 32;
    localparam int CNT_W        = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W       = $clog2(STACK_DEPTH);
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    // Token kinds.
    localparam logic [3:0] K_NUM   = 4'd0;
    localparam logic [3:0] K_IDENT = 4'd1;
    localparam logic [3:0] K_FUNC  = 4'd2;
    localparam logic [3:0] K_COMMA = 4'd3;
    localparam logic [3:0] K_OPER  = 4'd4;
    localparam logic [3:0] K_LPAR  = 4'd5;
    localparam logic [3:0] K_RPAR  = 4'd6;
    localparam logic [3:0] K_EQUAL = 4'd7;
    localparam logic [3:0] K_END   = 4'd8;

    // Operator codes.
    localparam logic [2:0] OP_PLUS  = 3'd0;
    localparam logic [2:0] OP_MINUS = 3'd1;
    localparam logic [2:0] OP_MUL   = 3'd2;
    localparam logic [2:0] OP_DIV   = 3'd3;
    localparam logic [2:0] OP_POW   = 3'd4;

    // Result status codes.
    localparam logic [2:0] ST_TOKEN    = 3'd0;
    localparam logic [2:0] ST_OK       = 3'd1;
    localparam logic [2:0] ST_SEP      = 3'd2;
    localparam logic [2:0] ST_NO_OPEN  = 3'd3;
    localparam logic [2:0] ST_NO_CLOSE = 3'd4;
    localparam logic [2:0] ST_BAD      = 3'd5;
    localparam logic [2:0] ST_OVERFLOW = 3'd6;

    // What the back end has to do with a token.
    typedef enum logic [2:0] {
        CL_EMIT,
        CL_PUSH,
        CL_COMMA,
        CL_OPER,
        CL_LPAR,
        CL_RPAR,
        CL_END,
        CL_BAD
    } t_cls;

    // One operator stack entry.
    typedef struct packed {
        logic [3:0]              kind;
        logic [2:0]              op;
        logic [PAYLOAD_BITS-1:0] payload;
    } t_entry;

    // A classified token as it travels through the queue.
    typedef struct packed {
        t_cls       cls;
        logic [1:0] prec;
        logic       right;
        t_entry     ent;
    } t_tok;

    // One result item.
    typedef struct packed {
        logic [2:0]              status;
        logic [3:0]              kind;
        logic [2:0]              op;
        logic [PAYLOAD_BITS-1:0] payload;
        logic                    last;
    } t_result;

    // Operator precedence: 1 for + and -, 2 for * and /, 3 for ^, 0 otherwise.
    function automatic logic [1:0] prec_of(input logic [2:0] op);
        logic [1:0] p;
        unique case (op)
            OP_PLUS, OP_MINUS: p = 2'd1;
            OP_MUL, OP_DIV:    p = 2'd2;
            OP_POW:            p = 2'd3;
            default:           p = 2'd0;
        endcase
        return p;
    endfunction

endpackage

### rtl/syr_front.sv
// Front end: accepts input beats, classifies each token and holds it in a short queue.
// Depends on syr_pkg.
module syr_front
    import syr_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [3:0]              i_func,
    input  logic [2:0]              i_op_kind,
    input  logic [PAYLOAD_BITS-1:0] i_payload,
    output logic                    o_q_valid,
    output t_tok                    o_q_tok,
    input  logic                    i_q_take
);

    t_tok              r_q [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_q_cnt;
    t_tok              cls_tok;
    logic              wr_en;
    logic              rd_en;

    // Classify the incoming token.
    always_comb begin
        cls_tok.ent.kind    = i_func;
        cls_tok.ent.op      = i_op_kind;
        cls_tok.ent.payload = i_payload;
        cls_tok.prec        = prec_of(i_op_kind);
        cls_tok.right       = (i_op_kind == OP_POW);
        unique case (i_func)
            K_NUM, K_IDENT, K_EQUAL: cls_tok.cls = CL_EMIT;
            K_FUNC:                  cls_tok.cls = CL_PUSH;
            K_COMMA:                 cls_tok.cls = CL_COMMA;
            K_OPER:                  cls_tok.cls = CL_OPER;
            K_LPAR:                  cls_tok.cls = CL_LPAR;
            K_RPAR:                  cls_tok.cls = CL_RPAR;
            K_END:                   cls_tok.cls = CL_END;
            default:                 cls_tok.cls = CL_BAD;
        endcase
    end

    // Queue handshake: stall only when full.
    assign o_stall   = (r_q_cnt == QCNT_W'(QUEUE_DEPTH));
    assign wr_en     = i_valid && !o_stall;
    assign o_q_valid = (r_q_cnt != '0);
    assign rd_en     = o_q_valid && i_q_take;
    assign o_q_tok   = r_q[r_rd_ptr];

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_q[r_wr_ptr] <= cls_tok;
        end
    end

    // Queue pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_q_cnt  <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (rd_en) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            if (wr_en && !rd_en) begin
                r_q_cnt <= r_q_cnt + QCNT_W'(1);
            end else if (!wr_en && rd_en) begin
                r_q_cnt <= r_q_cnt - QCNT_W'(1);
            end
        end
    end

    // The fill count never passes the queue depth.
    a_q_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_q_cnt <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue fill count beyond depth");

    // A take with an empty queue would lose track of the pointers.
    a_q_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_q_cnt == '0) |-> !rd_en)
        else $error("queue read while empty");

    // The pointers differ by exactly the fill count.
    a_q_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wr_ptr - r_rd_ptr) == QPTR_W'(r_q_cnt))
        else $error("queue pointers out of step with fill count");

endmodule

### rtl/syr_back.sv
// Back end: sequencer that runs the operator stack and delivers result beats.
// Depends on syr_pkg; fed by syr_front.
module syr_back
    import syr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_q_valid,
    input  t_tok    i_q_tok,
    output logic    o_q_take,
    output logic    o_valid,
    input  logic    i_stall,
    output t_result o_res
);

    typedef enum logic [2:0] {
        S_FETCH,
        S_EXEC,
        S_RPAR,
        S_RFUNC,
        S_DRAIN
    } t_state;

    t_state            r_state, n_state;
    t_tok              r_tok, n_tok;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [CNT_W-1:0]  r_bal, n_bal;
    logic              r_skip, n_skip;
    logic              r_out_valid;
    t_result           r_out;
    t_entry            r_mem [STACK_DEPTH];
    t_entry            r_top;
    logic              out_free;
    logic              emit;
    t_result           emit_rec;
    logic              push_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic              stk_empty;
    logic              stk_full;
    logic [1:0]        top_prec;
    logic              oper_pops;

    assign out_free  = !r_out_valid || !i_stall;
    assign stk_empty = (r_cnt == '0);
    assign stk_full  = (r_cnt >= CNT_W'(STACK_DEPTH));
    assign top_prec  = prec_of(r_top.op);
    assign oper_pops = !stk_empty && (r_top.kind == K_OPER) &&
                       (r_tok.right ? (r_tok.prec < top_prec) : (r_tok.prec <= top_prec));

    // Sequencer: one stack push or pop, and at most one result, per cycle.
    always_comb begin
        n_state  = r_state;
        n_tok    = r_tok;
        n_cnt    = r_cnt;
        n_bal    = r_bal;
        n_skip   = r_skip;
        o_q_take = 1'b0;
        push_en  = 1'b0;
        emit     = 1'b0;
        emit_rec = '0;
        unique case (r_state)
            S_FETCH: begin
                if (i_q_valid) begin
                    o_q_take = 1'b1;
                    n_tok    = i_q_tok;
                    n_state  = S_EXEC;
                end
            end
            S_EXEC: begin
                if (r_skip) begin
                    // Dropping tokens after an error until the end token.
                    if (r_tok.cls == CL_END) begin
                        n_skip = 1'b0;
                    end
                    n_state = S_FETCH;
                end else begin
                    unique case (r_tok.cls)
                        CL_EMIT: begin
                            if (out_free) begin
                                emit             = 1'b1;
                                emit_rec.status  = ST_TOKEN;
                                emit_rec.kind    = r_tok.ent.kind;
                                emit_rec.op      = r_tok.ent.op;
                                emit_rec.payload = r_tok.ent.payload;
                                n_state          = S_FETCH;
                            end
                        end
                        CL_PUSH, CL_LPAR: begin
                            if (!stk_full) begin
                                push_en = 1'b1;
                                n_cnt   = r_cnt + CNT_W'(1);
                                if (r_tok.cls == CL_LPAR) begin
                                    n_bal = r_bal + CNT_W'(1);
                                end
                                n_state = S_FETCH;
                            end else if (out_free) begin
                                emit            = 1'b1;
                                emit_rec.status = ST_OVERFLOW;
                                emit_rec.last   = 1'b1;
                                n_cnt           = '0;
                                n_bal           = '0;
                                n_skip          = 1'b1;
                                n_state         = S_FETCH;
                            end
                        end
                        CL_COMMA: begin
                            if (!stk_empty && r_top.kind != K_LPAR) begin
                                if (out_free) begin
                                    emit             = 1'b1;
                                    emit_rec.status  = ST_TOKEN;
                                    emit_rec.kind    = r_top.kind;
                                    emit_rec.op      = r_top.op;
                                    emit_rec.payload = r_top.payload;
                                    n_cnt            = r_cnt - CNT_W'(1);
                                end
                            end else if (stk_empty) begin
                                if (out_free) begin
                                    emit            = 1'b1;
                                    emit_rec.status = ST_SEP;
                                    emit_rec.last   = 1'b1;
                                    n_cnt           = '0;
                                    n_bal           = '0;
                                    n_skip          = 1'b1;
                                    n_state         = S_FETCH;
                                end
                            end else begin
                                n_state = S_FETCH;
                            end
                        end
                        CL_OPER: begin
                            if (oper_pops) begin
                                if (out_free) begin
                                    emit             = 1'b1;
                                    emit_rec.status  = ST_TOKEN;
                                    emit_rec.kind    = r_top.kind;
                                    emit_rec.op      = r_top.op;
                                    emit_rec.payload = r_top.payload;
                                    n_cnt            = r_cnt - CNT_W'(1);
                                end
                            end else if (!stk_full) begin
                                push_en = 1'b1;
                                n_cnt   = r_cnt + CNT_W'(1);
                                n_state = S_FETCH;
                            end else if (out_free) begin
                                emit            = 1'b1;
                                emit_rec.status = ST_OVERFLOW;
                                emit_rec.last   = 1'b1;
                                n_cnt           = '0;
                                n_bal           = '0;
                                n_skip          = 1'b1;
                                n_state         = S_FETCH;
                            end
                        end
                        CL_RPAR: begin
                            if (r_bal != '0) begin
                                n_bal   = r_bal - CNT_W'(1);
                                n_state = S_RPAR;
                            end else if (out_free) begin
                                emit            = 1'b1;
                                emit_rec.status = ST_NO_OPEN;
                                emit_rec.last   = 1'b1;
                                n_cnt           = '0;
                                n_bal           = '0;
                                n_skip          = 1'b1;
                                n_state         = S_FETCH;
                            end
                        end
                        CL_END: begin
                            if (r_bal == '0) begin
                                n_state = S_DRAIN;
                            end else if (out_free) begin
                                emit            = 1'b1;
                                emit_rec.status = ST_NO_CLOSE;
                                emit_rec.last   = 1'b1;
                                n_cnt           = '0;
                                n_bal           = '0;
                                n_skip          = 1'b0;
                                n_state         = S_FETCH;
                            end
                        end
                        CL_BAD: begin
                            if (out_free) begin
                                emit            = 1'b1;
                                emit_rec.status = ST_BAD;
                                emit_rec.last   = 1'b1;
                                n_cnt           = '0;
                                n_bal           = '0;
                                n_skip          = 1'b1;
                                n_state         = S_FETCH;
                            end
                        end
                    endcase
                end
            end
            S_RPAR: begin
                // Pop down to the matching open parenthesis.
                if (!stk_empty && r_top.kind != K_LPAR) begin
                    if (out_free) begin
                        emit             = 1'b1;
                        emit_rec.status  = ST_TOKEN;
                        emit_rec.kind    = r_top.kind;
                        emit_rec.op      = r_top.op;
                        emit_rec.payload = r_top.payload;
                        n_cnt            = r_cnt - CNT_W'(1);
                    end
                end else if (stk_empty) begin
                    if (out_free) begin
                        emit            = 1'b1;
                        emit_rec.status = ST_NO_OPEN;
                        emit_rec.last   = 1'b1;
                        n_cnt           = '0;
                        n_bal           = '0;
                        n_skip          = 1'b1;
                        n_state         = S_FETCH;
                    end
                end else begin
                    n_cnt   = r_cnt - CNT_W'(1);
                    n_state = S_RFUNC;
                end
            end
            S_RFUNC: begin
                // A function just under the dropped parenthesis goes out now.
                if (!stk_empty && r_top.kind == K_FUNC) begin
                    if (out_free) begin
                        emit             = 1'b1;
                        emit_rec.status  = ST_TOKEN;
                        emit_rec.kind    = r_top.kind;
                        emit_rec.op      = r_top.op;
                        emit_rec.payload = r_top.payload;
                        n_cnt            = r_cnt - CNT_W'(1);
                        n_state          = S_FETCH;
                    end
                end else begin
                    n_state = S_FETCH;
                end
            end
            S_DRAIN: begin
                // Empty the stack at the end token, then report the outcome.
                if (out_free) begin
                    emit = 1'b1;
                    if (stk_empty) begin
                        emit_rec.status = ST_OK;
                        emit_rec.last   = 1'b1;
                        n_cnt           = '0;
                        n_bal           = '0;
                        n_skip          = 1'b0;
                        n_state         = S_FETCH;
                    end else if (r_top.kind == K_LPAR || r_top.kind == K_RPAR) begin
                        emit_rec.status = ST_NO_CLOSE;
                        emit_rec.last   = 1'b1;
                        n_cnt           = '0;
                        n_bal           = '0;
                        n_skip          = 1'b0;
                        n_state         = S_FETCH;
                    end else begin
                        emit_rec.status  = ST_TOKEN;
                        emit_rec.kind    = r_top.kind;
                        emit_rec.op      = r_top.op;
                        emit_rec.payload = r_top.payload;
                        n_cnt            = r_cnt - CNT_W'(1);
                    end
                end
            end
            default: begin
                n_state = S_FETCH;
            end
        endcase
    end

    // Stack addressing: the top entry is read ahead for the next count.
    assign wr_addr = r_cnt[ADDR_W-1:0];
    assign rd_addr = (n_cnt == '0) ? '0 : ADDR_W'(n_cnt - CNT_W'(1));

    // Stack memory with registered read of the top entry and write forwarding.
    always_ff @(posedge i_clk) begin
        if (push_en) begin
            r_mem[wr_addr] <= r_tok.ent;
        end
        if (push_en && wr_addr == rd_addr) begin
            r_top <= r_tok.ent;
        end else begin
            r_top <= r_mem[rd_addr];
        end
    end

    // State, stack bookkeeping and the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_FETCH;
            r_cnt       <= '0;
            r_bal       <= '0;
            r_skip      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_bal   <= n_bal;
            r_skip  <= n_skip;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
        r_tok <= n_tok;
        if (emit) begin
            r_out <= emit_rec;
        end
    end

    assign o_valid = r_out_valid;
    assign o_res   = r_out;

    // Open parentheses are always a subset of the stack.
    a_bal_le_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bal <= r_cnt)
        else $error("parenthesis balance exceeds stack count");

    // The stack never grows past its depth.
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(STACK_DEPTH))
        else $error("stack count beyond depth");

    // A final status leaves an empty stack behind.
    a_status_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && emit_rec.last) |=> (r_cnt == '0 && r_bal == '0))
        else $error("stack not cleared after final status");

    // Nothing is delivered while tokens are being dropped.
    a_skip_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skip |-> !emit)
        else $error("result produced while skipping");

    // A new result is only loaded when the output register can take it.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_stall) |-> !emit)
        else $error("held result overwritten");

endmodule

### rtl/shunting_yard_rpn_converter.sv
// Top level of the shunting-yard infix-to-postfix converter.
// Joins syr_front (classify and queue) to syr_back (stack sequencer); uses syr_pkg.
//
//  Channel  Direction  Handshake            Beat fields
//  input    in         i_valid / o_stall    i_func, i_op_kind, i_payload
//  result   out        o_valid / i_stall    o_status, o_out_kind, o_out_op,
//                                           o_out_payload, o_last
//
// A token is written into the queue, from which the back end fetches it into its token
// register; the execute step then handles it, popping stack entries one at a time. A ')'
// then goes through S_RPAR, which pops down to the parenthesis and drops it, and S_RFUNC,
// which checks for a function beneath it; the end token goes through S_DRAIN, which pops
// the stack and then reports the status. The single stack read port sets this pace.
// Reset clears the queue, stack count, parenthesis balance and skip flag at once; the
// stack memory itself is not cleared. Either side may stall without loss: the queue and
// the output register hold their beats.
module shunting_yard_rpn_converter
    import syr_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [3:0]              i_func,
    input  logic [2:0]              i_op_kind,
    input  logic [PAYLOAD_BITS-1:0] i_payload,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [2:0]              o_status,
    output logic [3:0]              o_out_kind,
    output logic [2:0]              o_out_op,
    output logic [PAYLOAD_BITS-1:0] o_out_payload,
    output logic                    o_last
);

    logic    q_valid;
    t_tok    q_tok;
    logic    q_take;
    t_result res;

    syr_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_func    (i_func),
        .i_op_kind (i_op_kind),
        .i_payload (i_payload),
        .o_q_valid (q_valid),
        .o_q_tok   (q_tok),
        .i_q_take  (q_take)
    );

    syr_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_tok   (q_tok),
        .o_q_take  (q_take),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_res     (res)
    );

    // Unpack the result beat onto its ports.
    assign o_status      = res.status;
    assign o_out_kind    = res.kind;
    assign o_out_op      = res.op;
    assign o_out_payload = res.payload;
    assign o_last        = res.last;

endmodule

### test/testbench.sv
// Self-checking testbench for the shunting-yard infix-to-postfix converter.
// Drives token beats with random gaps and result stalls, predicts the postfix stream
// and statuses in a behavioural model, and compares every result beat; uses syr_pkg.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import syr_pkg::*;

    // Codes that the package does not name.
    localparam logic [3:0] K_OTHER  = 4'd9;
    localparam logic [2:0] OP_OTHER = 3'd5;

    localparam int RESET_CYCLES   = 7;
    localparam int HOLD_CYCLES    = 150;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int RANDOM_TOKENS  = 20;

    // Block ports.
    logic                    i_clk         = 1'b0;
    logic                    i_rst_n       = 1'b0;
    logic                    i_valid       = 1'b0;
    logic                    o_stall;
    logic [3:0]              i_func        = '0;
    logic [2:0]              i_op_kind     = '0;
    logic [PAYLOAD_BITS-1:0] i_payload     = '0;
    logic                    o_valid;
    logic                    i_stall       = 1'b0;
    logic [2:0]              o_status;
    logic [3:0]              o_out_kind;
    logic [2:0]              o_out_op;
    logic [PAYLOAD_BITS-1:0] o_out_payload;
    logic                    o_last;

    // Postfix predictor state.
    t_entry  op_stack [STACK_DEPTH];
    int      stack_cnt  = 0;
    int      paren_cnt  = 0;
    bit      dropping   = 1'b0;
    t_result rpn_expect [$];

    // Random statement under construction.
    t_entry  expr_q [$];

    // Run control and statistics.
    bit      steady       = 1'b0;
    bit      hold_request = 1'b0;
    int      hold_left    = 0;
    int      stall_wait   = 0;
    int      idle_cycles  = 0;
    int      error_count  = 0;
    int      tokens_in    = 0;
    int      live_tokens  = 0;
    int      results_seen = 0;
    int      error_status = 0;
    int      deepest      = 0;

    shunting_yard_rpn_converter u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_func       (i_func),
        .i_op_kind    (i_op_kind),
        .i_payload    (i_payload),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_status     (o_status),
        .o_out_kind   (o_out_kind),
        .o_out_op     (o_out_op),
        .o_out_payload(o_out_payload),
        .o_last       (o_last)
    );

    // 12 ns clock.
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic int op_rank(logic [2:0] op);
        case (op)
            OP_PLUS, OP_MINUS: return 1;
            OP_MUL, OP_DIV:    return 2;
            OP_POW:            return 3;
            default:           return 0;
        endcase
    endfunction

    function automatic void emit_token(t_entry e);
        t_result r;
        r.status  = ST_TOKEN;
        r.kind    = e.kind;
        r.op      = e.op;
        r.payload = e.payload;
        r.last    = 1'b0;
        rpn_expect.insert(rpn_expect.size(), r);
    endfunction

    function automatic void emit_status(logic [2:0] st);
        t_result r;
        r        = '0;
        r.status = st;
        r.last   = 1'b1;
        rpn_expect.insert(rpn_expect.size(), r);
    endfunction

    // An error clears the expression; all but the end-token errors drop input until the next end.
    function automatic void abort_expr(logic [2:0] st, bit skip);
        emit_status(st);
        error_status++;
        stack_cnt = 0;
        paren_cnt = 0;
        dropping  = skip;
    endfunction

    function automatic bit push_entry(t_entry e);
        if (stack_cnt >= STACK_DEPTH)
            return 1'b0;
        op_stack[stack_cnt] = e;
        stack_cnt++;
        if (stack_cnt > deepest)
            deepest = stack_cnt;
        return 1'b1;
    endfunction

    function automatic void pop_to_open();
        while (stack_cnt > 0 && op_stack[stack_cnt-1].kind != K_LPAR) begin
            stack_cnt--;
            emit_token(op_stack[stack_cnt]);
        end
    endfunction

    // Works out the result beats that one accepted token causes.
    function automatic void convert_token(t_entry tok);
        int     rank;
        int     top_rank;
        bit     clean;
        t_entry top;
        if (dropping) begin
            if (tok.kind == K_END)
                dropping = 1'b0;
            return;
        end
        live_tokens++;
        case (tok.kind)
            K_NUM, K_IDENT, K_EQUAL: begin
                emit_token(tok);
            end
            K_FUNC: begin
                if (!push_entry(tok))
                    abort_expr(ST_OVERFLOW, 1'b1);
            end
            K_COMMA: begin
                pop_to_open();
                if (stack_cnt == 0)
                    abort_expr(ST_SEP, 1'b1);
            end
            K_OPER: begin
                rank = op_rank(tok.op);
                while (stack_cnt > 0 && op_stack[stack_cnt-1].kind == K_OPER) begin
                    top_rank = op_rank(op_stack[stack_cnt-1].op);
                    // Power binds to the right, so it only yields to stronger operators.
                    if (tok.op == OP_POW ? rank < top_rank : rank <= top_rank) begin
                        stack_cnt--;
                        emit_token(op_stack[stack_cnt]);
                    end else
                        break;
                end
                if (!push_entry(tok))
                    abort_expr(ST_OVERFLOW, 1'b1);
            end
            K_LPAR: begin
                if (!push_entry(tok))
                    abort_expr(ST_OVERFLOW, 1'b1);
                else
                    paren_cnt++;
            end
            K_RPAR: begin
                if (paren_cnt == 0)
                    abort_expr(ST_NO_OPEN, 1'b1);
                else begin
                    paren_cnt--;
                    pop_to_open();
                    if (stack_cnt == 0)
                        abort_expr(ST_NO_OPEN, 1'b1);
                    else begin
                        // Drop the '(' and release a function waiting beneath it.
                        stack_cnt--;
                        if (stack_cnt > 0 && op_stack[stack_cnt-1].kind == K_FUNC) begin
                            stack_cnt--;
                            emit_token(op_stack[stack_cnt]);
                        end
                    end
                end
            end
            K_END: begin
                if (paren_cnt > 0)
                    abort_expr(ST_NO_CLOSE, 1'b0);
                else begin
                    clean = 1'b1;
                    while (stack_cnt > 0 && clean) begin
                        top = op_stack[stack_cnt-1];
                        if (top.kind == K_LPAR || top.kind == K_RPAR) begin
                            abort_expr(ST_NO_CLOSE, 1'b0);
                            clean = 1'b0;
                        end else begin
                            stack_cnt--;
                            emit_token(top);
                        end
                    end
                    if (clean) begin
                        emit_status(ST_OK);
                        stack_cnt = 0;
                        paren_cnt = 0;
                        dropping  = 1'b0;
                    end
                end
            end
            default: begin
                abort_expr(ST_BAD, 1'b1);
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Sender, receiver, checker and watchdog
    // ------------------------------------------------------------------

    // Offers one token beat after a random gap and returns at the edge that takes it.
    task automatic send_token(input logic [3:0] kind, input logic [2:0] op,
                              input logic [PAYLOAD_BITS-1:0] pl);
        int     gap;
        t_entry tok;
        gap = steady ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_func    <= kind;
        i_op_kind <= op;
        i_payload <= pl;
        do @(posedge i_clk); while (o_stall);
        tok.kind    = kind;
        tok.op      = op;
        tok.payload = pl;
        tokens_in++;
        convert_token(tok);
    endtask

    task automatic send_kind(input logic [3:0] kind);
        send_token(kind, 3'($urandom_range(0, 7)), PAYLOAD_BITS'($urandom()));
    endtask

    task automatic send_oper(input logic [2:0] op);
        send_token(K_OPER, op, PAYLOAD_BITS'($urandom()));
    endtask

    // Stops offering and waits until every predicted beat has arrived.
    task automatic wait_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (rpn_expect.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    // Result side: a random stall after each beat, plus an occasional long hold-off.
    always @(posedge i_clk) begin
        if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (o_valid && !i_stall)
            stall_wait = steady ? 0 : $urandom_range(0, 7);
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_stall <= 1'b1;
        end else if (stall_wait > 0) begin
            stall_wait = stall_wait - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // Compare every accepted result beat with the oldest prediction.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            results_seen++;
            if (rpn_expect.size() == 0) begin
                error_count++;
                $display("%0t: unexpected beat, expected none, got status %0d kind %0d op %0d",
                         $time, o_status, o_out_kind, o_out_op);
            end else begin
                want = rpn_expect.pop_front();
                if (o_status !== want.status) begin
                    error_count++;
                    $display("%0t: status mismatch, expected %0d, got %0d",
                             $time, want.status, o_status);
                end
                if (o_out_kind !== want.kind) begin
                    error_count++;
                    $display("%0t: kind mismatch, expected %0d, got %0d",
                             $time, want.kind, o_out_kind);
                end
                if (o_out_op !== want.op) begin
                    error_count++;
                    $display("%0t: op mismatch, expected %0d, got %0d",
                             $time, want.op, o_out_op);
                end
                if (o_out_payload !== want.payload) begin
                    error_count++;
                    $display("%0t: payload mismatch, expected %h, got %h",
                             $time, want.payload, o_out_payload);
                end
                if (o_last !== want.last) begin
                    error_count++;
                    $display("%0t: last mismatch, expected %0d, got %0d",
                             $time, want.last, o_last);
                end
            end
        end
    end

    // Ends the run if no beat moves on either side for too long.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall))
            idle_cycles = 0;
        else
            idle_cycles = idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no beat moved for %0d cycles, %0d results outstanding",
                     $time, idle_cycles, rpn_expect.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Random statement builder
    // ------------------------------------------------------------------

    function automatic t_entry make_token(logic [3:0] kind, logic [2:0] op);
        t_entry e;
        e.kind    = kind;
        e.op      = op;
        e.payload = PAYLOAD_BITS'($urandom());
        return e;
    endfunction

    function automatic void build_expr(int depth);
        int terms;
        terms = $urandom_range(1, 4);
        for (int i = 0; i < terms; i++) begin
            if (i > 0)
                expr_q.insert(expr_q.size(), make_token(K_OPER, 3'($urandom_range(0, 7))));
            build_term(depth);
        end
    endfunction

    function automatic void build_term(int depth);
        int pick;
        int args;
        pick = (depth >= 3) ? 0 : $urandom_range(0, 5);
        if (pick <= 2) begin
            expr_q.insert(expr_q.size(),
                          make_token(pick[0] ? K_IDENT : K_NUM, 3'($urandom_range(0, 7))));
        end else if (pick <= 4) begin
            expr_q.insert(expr_q.size(), make_token(K_LPAR, 3'($urandom_range(0, 7))));
            build_expr(depth + 1);
            expr_q.insert(expr_q.size(), make_token(K_RPAR, 3'($urandom_range(0, 7))));
        end else begin
            // Function call with one to three arguments.
            args = $urandom_range(1, 3);
            expr_q.insert(expr_q.size(), make_token(K_FUNC, 3'($urandom_range(0, 7))));
            expr_q.insert(expr_q.size(), make_token(K_LPAR, 3'($urandom_range(0, 7))));
            for (int a = 0; a < args; a++) begin
                if (a > 0)
                    expr_q.insert(expr_q.size(),
                                  make_token(K_COMMA, 3'($urandom_range(0, 7))));
                build_expr(depth + 1);
            end
            expr_q.insert(expr_q.size(), make_token(K_RPAR, 3'($urandom_range(0, 7))));
        end
    endfunction

    // Mostly well-formed statements; about one in five is broken at a random spot.
    function automatic void build_statement();
        int spot;
        expr_q.delete();
        if ($urandom_range(0, 3) == 0) begin
            expr_q.insert(expr_q.size(), make_token(K_IDENT, 3'($urandom_range(0, 7))));
            expr_q.insert(expr_q.size(), make_token(K_EQUAL, 3'($urandom_range(0, 7))));
        end
        build_expr(0);
        if ($urandom_range(0, 4) == 0) begin
            spot = $urandom_range(0, expr_q.size() - 1);
            case ($urandom_range(0, 2))
                0:       expr_q[spot] = make_token(4'($urandom_range(0, 15)),
                                                   3'($urandom_range(0, 7)));
                1:       expr_q.delete(spot);
                default: expr_q.insert(spot,
                                       make_token(4'($urandom_range(0, 15)),
                                                  3'($urandom_range(0, 7))));
            endcase
        end
        expr_q.insert(expr_q.size(), make_token(K_END, 3'($urandom_range(0, 7))));
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // a - b * c ^ d ^ e / f <other> g + h, with payload extremes on operands a and b.
    task automatic test_precedence();
        send_token(K_NUM, OP_PLUS, '0);
        send_oper(OP_MINUS);
        send_token(K_IDENT, OP_POW, '1);
        send_oper(OP_MUL);
        send_kind(K_NUM);
        send_oper(OP_POW);
        send_kind(K_NUM);
        send_oper(OP_POW);
        send_kind(K_IDENT);
        send_oper(OP_DIV);
        send_kind(K_NUM);
        send_oper(OP_OTHER);
        send_kind(K_NUM);
        send_oper(OP_PLUS);
        send_kind(K_NUM);
        send_kind(K_END);
        wait_drained();
    endtask

    // fn ( a , b ) = c
    task automatic test_groups();
        send_kind(K_FUNC);
        send_kind(K_LPAR);
        send_kind(K_NUM);
        send_kind(K_COMMA);
        send_kind(K_IDENT);
        send_kind(K_RPAR);
        send_kind(K_EQUAL);
        send_kind(K_NUM);
        send_kind(K_END);
        wait_drained();
    endtask

    // Separator outside a group, unmatched ')', unclosed '(' and an unknown kind.
    task automatic test_errors();
        send_kind(K_NUM);
        send_kind(K_COMMA);
        send_kind(K_NUM);
        send_kind(K_END);
        send_kind(K_RPAR);
        send_kind(K_END);
        send_kind(K_LPAR);
        send_kind(K_END);
        send_kind(K_OTHER);
        send_kind(K_END);
        wait_drained();
    endtask

    // Stack filled with '(' until a power chain runs out of room.
    task automatic test_overflow();
        repeat (STACK_DEPTH - 1) send_kind(K_LPAR);
        send_kind(K_NUM);
        send_oper(OP_POW);
        send_kind(K_NUM);
        send_oper(OP_POW);
        send_kind(K_END);
        wait_drained();
    endtask

    // Receiver holds off for a long stretch while a long sum keeps arriving.
    task automatic test_hold_off();
        hold_request = 1'b1;
        send_kind(K_NUM);
        repeat (8) begin
            send_oper(3'($urandom_range(OP_PLUS, OP_MINUS)));
            send_kind(K_NUM);
        end
        send_kind(K_END);
        wait_drained();
    endtask

    // Random statements, some sent back to back with no idling at all.
    task automatic test_random();
        int target;
        target = live_tokens + RANDOM_TOKENS;
        while (live_tokens < target) begin
            steady = ($urandom_range(0, 3) == 0);
            build_statement();
            foreach (expr_q[k])
                send_token(expr_q[k].kind, expr_q[k].op, expr_q[k].payload);
            // Now and then the sender waits for the block to empty completely.
            if ($urandom_range(0, 5) == 0)
                wait_drained();
        end
        steady = 1'b0;
        wait_drained();
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_precedence();
        test_groups();
        test_errors();
        test_overflow();
        test_hold_off();
        test_random();
        repeat (20) @(posedge i_clk);
        if (rpn_expect.size() != 0) begin
            error_count++;
            $display("%0t: %0d expected beats never arrived", $time, rpn_expect.size());
        end
        $display("Sent %0d tokens (%0d outside error recovery), checked %0d result beats.",
                 tokens_in, live_tokens, results_seen);
        $display("Saw %0d error statuses; deepest operator stack %0d of %0d.",
                 error_status, deepest, STACK_DEPTH);
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
